// ----- rtl/ttu_pkg.sv -----
// Shared widths, codes and types of the trust table update block.
`default_nettype none

package ttu_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int DEF_ID_BITS = 64;

   localparam int KIND_W      = 2;
   localparam int NODE_ID_W   = 64;
   localparam int LEVEL_W     = 32;
   localparam int TIME_W      = 32;
   localparam int PENALTY_W   = 31;
   localparam int BEST_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PENALTY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFRESH = 2'd1;

   localparam logic [PENALTY_W-1:0] PENALTY_RESET = 31'd65536;
   localparam logic [TIME_W-1:0]    REFRESH_RESET = 32'd60;

   typedef struct packed {
      logic [PENALTY_W-1:0] penalty;
      logic [TIME_W-1:0]    refresh_period;
   } cfg_type;

   typedef struct packed {
      logic                      found;
      logic signed [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]         deadline;
      logic [BEST_W-1:0]         best_index;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/trust_table_update.sv -----
// Top level of the trust table update block: ports, registers, result buffer.
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   kind, node_id, score_delta, current_time
//  rsp      out  rsp_valid/rsp_stall   node_found, node_level, node_deadline, best_index
//  csr      in   csr_valid/csr_ready   csr_index, csr_data
//
//  An item runs from accept to result through one read of the entry memory per
//  entry plus the update, report and fill steps.
//  Reset clears the state and all valid bits and loads the csr defaults; no clearing pass.
//  A finished result waits in the output register while the next item runs;
//  a second result then holds in the sequencer until rsp_stall drops.
`default_nettype none

module trust_table_update #(
   parameter int TABLE_ENTRIES = ttu_pkg::DEF_ENTRIES,
   parameter int ID_BITS       = ttu_pkg::DEF_ID_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [ttu_pkg::KIND_W-1:0]            req_kind,
   input  wire logic [ttu_pkg::NODE_ID_W-1:0]         req_node_id,
   input  wire logic signed [ttu_pkg::LEVEL_W-1:0]    req_score_delta,
   input  wire logic [ttu_pkg::TIME_W-1:0]            req_current_time,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_node_found,
   output logic signed [ttu_pkg::LEVEL_W-1:0]         rsp_node_level,
   output logic [ttu_pkg::TIME_W-1:0]                 rsp_node_deadline,
   output logic [ttu_pkg::BEST_W-1:0]                 rsp_best_index,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ttu_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [ttu_pkg::CSR_DATA_W-1:0]        csr_data
);
   import ttu_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);

   cfg_type            cfg_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   rsp_type            result;
   logic               res_valid;
   logic               res_take;

   logic               tbl_clear;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ID_BITS-1:0] rd_id;
   logic signed [31:0] rd_level;
   logic [31:0]        rd_deadline;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ID_BITS-1:0] wr_id;
   logic signed [31:0] wr_level;
   logic [31:0]        wr_deadline;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.penalty        <= PENALTY_RESET;
         cfg_ff.refresh_period <= REFRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PENALTY: cfg_ff.penalty        <= csr_data[PENALTY_W-1:0];
            CSR_REFRESH: cfg_ff.refresh_period <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   ttu_table #(
      .ENTRIES (TABLE_ENTRIES),
      .ID_BITS (ID_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .clear       (tbl_clear),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_id       (rd_id),
      .rd_level    (rd_level),
      .rd_deadline (rd_deadline),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_id       (wr_id),
      .wr_level    (wr_level),
      .wr_deadline (wr_deadline)
   );

   ttu_engine #(
      .ENTRIES (TABLE_ENTRIES),
      .ID_BITS (ID_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_node_id      (req_node_id[ID_BITS-1:0]),
      .req_score_delta  (req_score_delta),
      .req_current_time (req_current_time),
      .cfg              (cfg_ff),
      .result           (result),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .tbl_clear        (tbl_clear),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_id            (rd_id),
      .rd_level         (rd_level),
      .rd_deadline      (rd_deadline),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_id            (wr_id),
      .wr_level         (wr_level),
      .wr_deadline      (wr_deadline)
   );

   // load the output register when it is empty or being drained
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_node_found    = rsp_ff.found;
   assign rsp_node_level    = rsp_ff.level;
   assign rsp_node_deadline = rsp_ff.deadline;
   assign rsp_best_index    = rsp_ff.best_index;

endmodule

`default_nettype wire

// ----- rtl/ttu_table.sv -----
// Entry memory of the trust table with per-entry valid bits.
`default_nettype none

module ttu_table #(
   parameter int ENTRIES = 16,
   parameter int ID_BITS = 64,
   localparam int AW = $clog2(ENTRIES)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output logic [ID_BITS-1:0]       rd_id,
   output logic signed [31:0]       rd_level,
   output logic [31:0]              rd_deadline,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [ID_BITS-1:0]  wr_id,
   input  wire logic signed [31:0]  wr_level,
   input  wire logic [31:0]         wr_deadline
);
   import ttu_pkg::*;

   localparam int DW = ID_BITS + LEVEL_W + TIME_W;

   logic [DW-1:0]      mem_ff [ENTRIES];
   logic [DW-1:0]      rd_data_ff;
   logic               rd_valid_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_id, wr_level, wr_deadline};
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written since reset or clear reads as zero
   assign rd_id       = rd_valid_ff ? rd_data_ff[DW-1 -: ID_BITS] : '0;
   assign rd_level    = rd_valid_ff ? rd_data_ff[LEVEL_W+TIME_W-1 -: LEVEL_W] : '0;
   assign rd_deadline = rd_valid_ff ? rd_data_ff[TIME_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/ttu_engine.sv -----
// Sequencer that walks the table: ages, updates, fills and reports.
`default_nettype none

module ttu_engine #(
   parameter int ENTRIES = 16,
   parameter int ID_BITS = 64,
   localparam int AW = $clog2(ENTRIES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_kind,
   input  wire logic [ID_BITS-1:0]     req_node_id,
   input  wire logic signed [31:0]     req_score_delta,
   input  wire logic [31:0]            req_current_time,
   input  wire ttu_pkg::cfg_type       cfg,
   output ttu_pkg::rsp_type            result,
   output logic                        res_valid,
   input  wire logic                   res_take,
   output logic                        tbl_clear,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   input  wire logic [ID_BITS-1:0]     rd_id,
   input  wire logic signed [31:0]     rd_level,
   input  wire logic [31:0]            rd_deadline,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [ID_BITS-1:0]          wr_id,
   output logic signed [31:0]          wr_level,
   output logic [31:0]                 wr_deadline
);
   import ttu_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] CTR_END = CW'(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FILL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic logic signed [31:0] sat_level(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

   function automatic logic [31:0] add_deadline(input logic [31:0] now,
                                                input logic [31:0] period);
      logic [32:0] s;
      s = {1'b0, now} + {1'b0, period};
      return s[32] ? 32'hffff_ffff : s[31:0];
   endfunction

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff;
   logic [ID_BITS-1:0] id_ff;
   logic signed [31:0] score_ff;
   logic [31:0]        now_ff;
   logic [31:0]        newdl_ff;
   logic [CW-1:0]      ctr_ff;

   logic               s1_valid_ff;
   logic [AW-1:0]      s1_idx_ff;
   logic               s2_valid_ff;
   logic [AW-1:0]      s2_idx_ff;
   logic [ID_BITS-1:0] s2_id_ff;
   logic signed [31:0] s2_level_ff;
   logic [31:0]        s2_dl_ff;

   logic               found_upd_ff;
   logic               free_ff;
   logic [AW-1:0]      free_idx_ff;
   logic               lk_found_ff;
   logic [AW-1:0]      lk_idx_ff;
   logic signed [31:0] lk_level_ff;
   logic [31:0]        lk_dl_ff;
   logic [AW-1:0]      best_idx_ff;
   logic signed [31:0] best_level_ff;

   logic               accept;
   logic               is_upd;
   logic               active;
   logic               match;
   logic               late;
   logic               upd_match;
   logic               upd_late;
   logic               scan_wr;
   logic               do_fill;
   logic signed [33:0] lvl_x;
   logic signed [33:0] add_x;
   logic signed [33:0] pen_x;
   logic signed [33:0] sum;
   logic signed [31:0] new_level;
   logic signed [31:0] post_level;
   logic [31:0]        post_dl;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign tbl_clear = accept && (req_kind == KIND_CLEAR);
   assign is_upd    = (kind_ff == KIND_UPDATE);

   assign rd_en   = (state_ff == ST_SCAN) && (ctr_ff != CTR_END);
   assign rd_addr = ctr_ff[AW-1:0];

   // update stage: one entry per cycle, straight from the read data
   assign active    = rd_level > 32'sd0;
   assign match     = rd_id == id_ff;
   assign late      = now_ff > rd_deadline;
   assign upd_match = s1_valid_ff && is_upd && active && match;
   assign upd_late  = s1_valid_ff && is_upd && active && !match && late;
   assign scan_wr   = upd_match || upd_late;

   assign lvl_x = {{2{rd_level[31]}}, rd_level};
   assign add_x = match ? {{2{score_ff[31]}}, score_ff} : 34'sd0;
   assign pen_x = late ? {3'b000, cfg.penalty} : 34'sd0;
   assign sum   = lvl_x + add_x - pen_x;

   assign new_level  = sat_level(sum);
   assign post_level = scan_wr ? new_level : rd_level;
   assign post_dl    = scan_wr ? newdl_ff : rd_deadline;

   assign do_fill = is_upd && !found_upd_ff && (score_ff > 32'sd0) && free_ff;

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = s1_idx_ff;
      wr_id       = rd_id;
      wr_level    = new_level;
      wr_deadline = newdl_ff;
      if (state_ff == ST_FILL) begin
         wr_en    = do_fill;
         wr_addr  = free_idx_ff;
         wr_id    = id_ff;
         wr_level = score_ff;
      end else if (state_ff == ST_SCAN) begin
         wr_en = scan_wr;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (ctr_ff == CTR_END && !s1_valid_ff && !s2_valid_ff) state_in = ST_FILL;
         end
         ST_FILL: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         found_upd_ff <= 1'b0;
         free_ff      <= 1'b0;
         lk_found_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
         if (accept) begin
            ctr_ff       <= '0;
            found_upd_ff <= 1'b0;
            free_ff      <= 1'b0;
            lk_found_ff  <= 1'b0;
         end else begin
            if (rd_en) ctr_ff <= ctr_ff + 1'b1;
            if (upd_match) found_upd_ff <= 1'b1;
            if (s1_valid_ff && is_upd && !active) free_ff <= 1'b1;
            if (s2_valid_ff && !lk_found_ff && s2_id_ff == id_ff) lk_found_ff <= 1'b1;
            if (state_ff == ST_FILL && do_fill) lk_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         id_ff    <= req_node_id;
         score_ff <= req_score_delta;
         now_ff   <= req_current_time;
         newdl_ff <= add_deadline(req_current_time, cfg.refresh_period);
      end
      s1_idx_ff   <= rd_addr;
      s2_idx_ff   <= s1_idx_ff;
      s2_id_ff    <= rd_id;
      s2_level_ff <= post_level;
      s2_dl_ff    <= post_dl;
      // keep the last free slot seen
      if (s1_valid_ff && is_upd && !active) free_idx_ff <= s1_idx_ff;
      // report stage: first match and first maximum over the updated entries
      if (s2_valid_ff) begin
         if (!lk_found_ff && s2_id_ff == id_ff) begin
            lk_idx_ff   <= s2_idx_ff;
            lk_level_ff <= s2_level_ff;
            lk_dl_ff    <= s2_dl_ff;
         end
         if (s2_idx_ff == '0 || s2_level_ff > best_level_ff) begin
            best_idx_ff   <= s2_idx_ff;
            best_level_ff <= s2_level_ff;
         end
      end
      // fold the newly filled slot into the report
      if (state_ff == ST_FILL && do_fill) begin
         if (!lk_found_ff || free_idx_ff <= lk_idx_ff) begin
            lk_idx_ff   <= free_idx_ff;
            lk_level_ff <= score_ff;
            lk_dl_ff    <= newdl_ff;
         end
         if (score_ff > best_level_ff ||
             (score_ff == best_level_ff && free_idx_ff < best_idx_ff)) begin
            best_idx_ff   <= free_idx_ff;
            best_level_ff <= score_ff;
         end
      end
   end

   assign res_valid         = (state_ff == ST_DONE);
   assign result.found      = lk_found_ff;
   assign result.level      = lk_found_ff ? lk_level_ff : 32'sd0;
   assign result.deadline   = lk_found_ff ? lk_dl_ff : 32'd0;
   assign result.best_index = BEST_W'(best_idx_ff);

   a_scan_wr_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && wr_en) |-> wr_addr == $past(rd_addr))
      else $error("scan write does not target the entry read one cycle before");

   a_no_wr_unless_upd: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && kind_ff != KIND_UPDATE) |-> !wr_en)
      else $error("table written by a query or clear item");

   a_fill_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (ctr_ff == CTR_END && !s1_valid_ff && !s2_valid_ff))
      else $error("fill step entered before the walk drained");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (res_valid && kind_ff == KIND_CLEAR) |->
         (result.level == 32'sd0 && result.deadline == 32'd0 && best_idx_ff == '0))
      else $error("clear item reports a nonzero entry");

endmodule

`default_nettype wire

// ----- sim/trust_table_update_tb.sv -----
// Self-checking testbench for the trust table update block: table predictor plus random traffic.
`timescale 1ns / 1ps

module trust_table_update_tb;
   import ttu_pkg::*;

   class trust_tracker;
      localparam int     ENTRIES   = DEF_ENTRIES;
      localparam longint LEVEL_MAX = 64'sh0000_0000_7FFF_FFFF;
      localparam longint LEVEL_MIN = -64'sh0000_0000_8000_0000;

      cfg_type                   cfg;
      logic [NODE_ID_W-1:0]      ids [ENTRIES];
      logic signed [LEVEL_W-1:0] levels [ENTRIES];
      logic [TIME_W-1:0]         deadlines [ENTRIES];
      rsp_type                   pending_reports [$];
      int                        mismatches;

      function new();
         clear_table();
         cfg.penalty        = PENALTY_RESET;
         cfg.refresh_period = REFRESH_RESET;
         mismatches         = 0;
      endfunction

      function void clear_table();
         for (int i = 0; i < ENTRIES; i++) begin
            ids[i]       = '0;
            levels[i]    = '0;
            deadlines[i] = '0;
         end
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
         if (index == CSR_PENALTY) begin
            cfg.penalty = data[PENALTY_W-1:0];
         end else if (index == CSR_REFRESH) begin
            cfg.refresh_period = data;
         end
      endfunction

      function logic [TIME_W-1:0] next_deadline(logic [TIME_W-1:0] now);
         logic [TIME_W:0] sum;
         sum = {1'b0, now} + {1'b0, cfg.refresh_period};
         return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      endfunction

      function logic signed [LEVEL_W-1:0] saturate(longint v);
         if (v > LEVEL_MAX) begin
            v = LEVEL_MAX;
         end else if (v < LEVEL_MIN) begin
            v = LEVEL_MIN;
         end
         return v[LEVEL_W-1:0];
      endfunction

      // Free slots are judged on the levels held before this update.
      function void score_and_age(logic [NODE_ID_W-1:0] id,
                                  logic signed [LEVEL_W-1:0] score,
                                  logic [TIME_W-1:0] now);
         bit     matched;
         bit     have_free;
         bit     late;
         int     free_slot;
         longint sum;
         matched   = 1'b0;
         have_free = 1'b0;
         free_slot = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (levels[i] > 0) begin
               late = now > deadlines[i];
               if (ids[i] == id) begin
                  sum = longint'(levels[i]) + longint'(score);
                  if (late) sum -= longint'(cfg.penalty);
                  levels[i]    = saturate(sum);
                  deadlines[i] = next_deadline(now);
                  matched      = 1'b1;
               end else if (late) begin
                  levels[i]    = saturate(longint'(levels[i]) - longint'(cfg.penalty));
                  deadlines[i] = next_deadline(now);
               end
            end else begin
               have_free = 1'b1;
               free_slot = i;
            end
         end
         if (!matched && score > 0 && have_free) begin
            ids[free_slot]       = id;
            levels[free_slot]    = score;
            deadlines[free_slot] = next_deadline(now);
         end
      endfunction

      function rsp_type predict_report(logic [KIND_W-1:0] kind,
                                       logic [NODE_ID_W-1:0] id,
                                       logic signed [LEVEL_W-1:0] score,
                                       logic [TIME_W-1:0] now);
         rsp_type r;
         int      best;
         r    = '0;
         best = 0;
         if (kind == KIND_UPDATE) begin
            score_and_age(id, score, now);
         end else if (kind == KIND_CLEAR) begin
            clear_table();
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (!r.found && ids[i] == id) begin
               r.found    = 1'b1;
               r.level    = levels[i];
               r.deadline = deadlines[i];
            end
            if (levels[i] > levels[best]) best = i;
         end
         r.best_index = best[BEST_W-1:0];
         return r;
      endfunction

      function void note_item(logic [KIND_W-1:0] kind, logic [NODE_ID_W-1:0] id,
                              logic signed [LEVEL_W-1:0] score,
                              logic [TIME_W-1:0] now);
         pending_reports.push_back(predict_report(kind, id, score, now));
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
         mismatches++;
      endtask

      task check_report(rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            report("result with nothing expected", 64'd0, 64'd0);
         end else begin
            want = pending_reports.pop_front();
            if (got.found !== want.found)
               report("node_found", 64'(got.found), 64'(want.found));
            if (got.level !== want.level)
               report("node_level", 64'(got.level), 64'(want.level));
            if (got.deadline !== want.deadline)
               report("node_deadline", 64'(got.deadline), 64'(want.deadline));
            if (got.best_index !== want.best_index)
               report("best_index", 64'(got.best_index), 64'(want.best_index));
         end
      endtask
   endclass

   localparam logic [KIND_W-1:0]      KIND_SPARE  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd2;
   localparam int                     CYCLE_LIMIT = 400000;
   localparam int                     PHASE_ITEMS = 110;
   localparam int                     LATENCY     = DEF_ENTRIES + 5;
   localparam logic [NODE_ID_W-1:0]   NODE_A      = 64'h0123_4567_89AB_CDEF;
   localparam logic [NODE_ID_W-1:0]   NODE_B      = 64'hFEDC_BA98_7654_3210;
   localparam logic [NODE_ID_W-1:0]   NODE_C      = 64'h0000_0000_0000_00C3;
   localparam logic [NODE_ID_W-1:0]   NODE_D      = 64'h8000_0000_0000_0001;
   localparam logic [NODE_ID_W-1:0]   FILL_BASE   = 64'h0000_5A00_0000_0000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [KIND_W-1:0]           req_kind;
   logic [NODE_ID_W-1:0]        req_node_id;
   logic signed [LEVEL_W-1:0]   req_score_delta;
   logic [TIME_W-1:0]           req_current_time;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_node_found;
   logic signed [LEVEL_W-1:0]   rsp_node_level;
   logic [TIME_W-1:0]           rsp_node_deadline;
   logic [BEST_W-1:0]           rsp_best_index;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   trust_tracker                sb;
   logic [NODE_ID_W-1:0]        node_pool [8];
   logic [TIME_W-1:0]           now_stamp;
   bit                          calm;
   int                          long_hold;
   int                          cycles;

   trust_table_update dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_node_id       (req_node_id),
      .req_score_delta   (req_score_delta),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_node_found    (rsp_node_found),
      .rsp_node_level    (rsp_node_level),
      .rsp_node_deadline (rsp_node_deadline),
      .rsp_best_index    (rsp_best_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: check accepted items, then pick the stall for the next cycle.
   initial begin
      rsp_type got;
      int      stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.found      = rsp_node_found;
            got.level      = rsp_node_level;
            got.deadline   = rsp_node_deadline;
            got.best_index = rsp_best_index;
            sb.check_report(got);
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Hold valid high across back-to-back items; lower it only for a gap.
   task send_item(input logic [KIND_W-1:0] kind, input logic [NODE_ID_W-1:0] id,
                  input logic signed [LEVEL_W-1:0] score, input logic [TIME_W-1:0] now);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_node_id      <= id;
      req_score_delta  <= score;
      req_current_time <= now;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_item(kind, id, score, now);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task drain_reports();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task program_register(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task run_random_items(input int count, input int calm_at, input int hold_at);
      logic [KIND_W-1:0]         kind;
      logic [NODE_ID_W-1:0]      id;
      logic signed [LEVEL_W-1:0] score;
      logic [TIME_W:0]           later;
      int                        pick;
      for (int n = 0; n < count; n++) begin
         if (n == calm_at) calm = 1'b1;
         // Starve the result side while items keep coming, so the input backs up.
         if (n == hold_at) long_hold = 250;
         pick = $urandom_range(0, 99);
         kind = pick < 72 ? KIND_UPDATE : pick < 87 ? KIND_QUERY :
                pick < 90 ? KIND_CLEAR : KIND_SPARE;
         id = ($urandom_range(0, 9) < 7) ? node_pool[$urandom_range(0, 7)] : {$urandom, $urandom};
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: score = $urandom_range(1, 32'h0004_0000);
            5:             score = 32'd0 - $urandom_range(0, 32'h0004_0000);
            6:             score = $urandom;
            7:             score = 32'sh7FFF_FFFF;
            8:             score = 32'sh8000_0000;
            default:       score = $urandom_range(0, 256);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: later = {1'b0, now_stamp} + $urandom_range(0, 30);
            6:                later = {1'b0, now_stamp} + $urandom_range(0, 400);
            7:                later = {1'b0, $urandom};
            8:                later = {1'b0, 32'hFFFF_FFFF - $urandom_range(0, 100)};
            default:          later = {1'b0, now_stamp};
         endcase
         now_stamp = later[TIME_W] ? '1 : later[TIME_W-1:0];
         send_item(kind, id, score, now_stamp);
      end
   endtask

   initial begin
      sb        = new();
      calm      = 1'b0;
      long_hold = 0;
      now_stamp = '0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_QUERY;
      req_node_id      <= '0;
      req_score_delta  <= '0;
      req_current_time <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_PENALTY;
      csr_data         <= '0;
      node_pool[0] = '0;
      node_pool[1] = '1;
      node_pool[2] = NODE_A;
      node_pool[3] = NODE_D;
      node_pool[4] = 64'd1;
      for (int i = 5; i < 8; i++) node_pool[i] = {$urandom, $urandom};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items on reset register values.
      send_item(KIND_QUERY, '0, '0, '0);
      send_item(KIND_UPDATE, NODE_A, 32'sh0001_0000, 32'd100);
      send_item(KIND_UPDATE, NODE_A, 32'sh7FFF_FFFF, 32'd100);
      send_item(KIND_UPDATE, NODE_B, -32'sd5, 32'd100);
      send_item(KIND_UPDATE, NODE_C, 32'sd0, 32'd100);
      send_item(KIND_UPDATE, '1, 32'sd1, 32'd100);
      send_item(KIND_UPDATE, '1, 32'sh8000_0000, 32'd200);
      send_item(KIND_QUERY, '1, '0, 32'd200);
      send_item(KIND_UPDATE, NODE_D, 32'sh0000_8000, 32'hFFFF_FFFF);
      send_item(KIND_SPARE, NODE_A, 32'sh1234_5678, 32'hFFFF_FFFF);
      send_item(KIND_CLEAR, NODE_A, '0, '0);
      // Fill every slot, then one more that finds the table full.
      for (int i = 0; i <= DEF_ENTRIES; i++) begin
         send_item(KIND_UPDATE, FILL_BASE + i, (i + 1) * 4096, 32'd1000);
      end
      // Deadline equal to now: not yet passed.
      send_item(KIND_UPDATE, FILL_BASE, 32'sh0000_0100, 32'd1060);
      drain_reports();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               program_register(CSR_PENALTY, 32'h8001_0000);
               program_register(CSR_REFRESH, 32'd60);
            end
            1: begin
               program_register(CSR_PENALTY, 32'd0);
               program_register(CSR_REFRESH, 32'd0);
            end
            2: begin
               program_register(CSR_PENALTY, 32'h7FFF_FFFF);
               program_register(CSR_REFRESH, 32'hFFFF_FFFF);
            end
            3: begin
               program_register(CSR_PENALTY, $urandom);
               program_register(CSR_REFRESH, $urandom_range(0, 300));
               program_register(CSR_UNUSED, $urandom);
            end
            default: begin
               program_register(CSR_PENALTY, $urandom_range(1, 32'h0003_0000));
               program_register(CSR_REFRESH, $urandom_range(1, 120));
            end
         endcase
         run_random_items(PHASE_ITEMS, (phase == 4) ? PHASE_ITEMS / 2 : -1,
                          (phase == 2) ? 20 : -1);
         drain_reports();
      end

      repeat (3 * LATENCY) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/ttu_pkg.sv
rtl/ttu_table.sv
rtl/ttu_engine.sv
rtl/trust_table_update.sv
sim/trust_table_update_tb.sv
